>>> hdl/adcd_pkg.sv
// Package for the accelerometer double-click detector.
// Types, click codes, register indexes and reset values; no dependencies.
package adcd_pkg;

    localparam int unsigned ACCEL_W  = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SQ_W     = 31;
    localparam int unsigned ENERGY_W = 32;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW_MS = 2'd2;

    localparam logic [CFG_W-1:0] RST_HIT_THRESHOLD    = 16'd40000;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS      = 16'd50;
    localparam logic [CFG_W-1:0] RST_DOUBLE_WINDOW_MS = 16'd300;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] now_ms;
    } t_event;

endpackage

>>> hdl/adcd_front.sv
// Front end: squares the sample, compares energy to threshold squared.
// Emits one classified event per sample; uses adcd_pkg.
module adcd_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [adcd_pkg::ACCEL_W-1:0]   i_accel_x,
    input  logic signed [adcd_pkg::ACCEL_W-1:0]   i_accel_y,
    input  logic signed [adcd_pkg::ACCEL_W-1:0]   i_accel_z,
    input  logic        [adcd_pkg::TIME_W-1:0]    i_now_ms,
    input  logic        [adcd_pkg::CFG_W-1:0]     i_hit_threshold,
    output logic                                  o_push,
    output adcd_pkg::t_event                      o_event,
    input  logic                                  i_full
);

    logic                               r_valid;
    logic [adcd_pkg::SQ_W-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic [adcd_pkg::ENERGY_W-1:0]      r_limit;
    logic [adcd_pkg::TIME_W-1:0]        r_now_ms;
    logic signed [2*adcd_pkg::ACCEL_W-1:0] ext_x, ext_y, ext_z;
    logic signed [2*adcd_pkg::ACCEL_W-1:0] sq_x, sq_y, sq_z;
    logic [adcd_pkg::ENERGY_W-1:0]      thr_ext;
    logic [adcd_pkg::ENERGY_W-1:0]      energy;
    logic                               advance;
    logic                               accept;

    assign advance = !r_valid || !i_full;
    assign o_stall = !advance;
    assign accept  = i_valid && advance;
    assign o_push  = r_valid && !i_full;

    assign ext_x = {{adcd_pkg::ACCEL_W{i_accel_x[adcd_pkg::ACCEL_W-1]}}, i_accel_x};
    assign ext_y = {{adcd_pkg::ACCEL_W{i_accel_y[adcd_pkg::ACCEL_W-1]}}, i_accel_y};
    assign ext_z = {{adcd_pkg::ACCEL_W{i_accel_z[adcd_pkg::ACCEL_W-1]}}, i_accel_z};
    assign thr_ext = {{(adcd_pkg::ENERGY_W-adcd_pkg::CFG_W){1'b0}}, i_hit_threshold};

    assign sq_x = ext_x * ext_x;
    assign sq_y = ext_y * ext_y;
    assign sq_z = ext_z * ext_z;

    assign energy = {1'b0, r_sq_x} + {1'b0, r_sq_y} + {1'b0, r_sq_z};

    assign o_event.hit    = energy > r_limit;
    assign o_event.now_ms = r_now_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_x   <= sq_x[adcd_pkg::SQ_W-1:0];
            r_sq_y   <= sq_y[adcd_pkg::SQ_W-1:0];
            r_sq_z   <= sq_z[adcd_pkg::SQ_W-1:0];
            r_limit  <= thr_ext * thr_ext;
            r_now_ms <= i_now_ms;
        end
    end

endmodule

>>> hdl/adcd_fifo.sv
// Short event queue between front and back ends.
// Register array with head/tail pointers and a fill count; uses adcd_pkg.
module adcd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  adcd_pkg::t_event i_event,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output adcd_pkg::t_event o_event
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    adcd_pkg::t_event r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == FULL;
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_event = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

endmodule

>>> hdl/adcd_back.sv
// Back end: debounce, arm/window tracking and click reporting.
// Pops one event per cycle into the output register unless the queue is empty or the output stalls; uses adcd_pkg.
module adcd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  adcd_pkg::t_event                    i_event,
    output logic                                o_pop,
    input  logic [adcd_pkg::CFG_W-1:0]          i_debounce_ms,
    input  logic [adcd_pkg::CFG_W-1:0]          i_double_window_ms,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [adcd_pkg::KIND_W-1:0]         o_click_kind
);

    logic [adcd_pkg::TIME_W-1:0] r_last_hit_ms, n_last_hit_ms;
    logic [adcd_pkg::TIME_W-1:0] r_first_hit_ms, n_first_hit_ms;
    logic                        r_armed, n_armed;
    logic                        r_valid;
    logic [adcd_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [adcd_pkg::TIME_W-1:0] since_last, since_first;
    logic                        counted, in_window;

    assign o_pop        = !i_empty && (!r_valid || !i_stall);
    assign o_valid      = r_valid;
    assign o_click_kind = r_kind;

    assign since_last  = i_event.now_ms - r_last_hit_ms;
    assign since_first = i_event.now_ms - r_first_hit_ms;
    assign counted     = i_event.hit &&
                         (since_last > {{(adcd_pkg::TIME_W-adcd_pkg::CFG_W){1'b0}}, i_debounce_ms});
    assign in_window   = since_first <=
                         {{(adcd_pkg::TIME_W-adcd_pkg::CFG_W){1'b0}}, i_double_window_ms};

    always_comb begin
        n_last_hit_ms  = r_last_hit_ms;
        n_first_hit_ms = r_first_hit_ms;
        n_armed        = r_armed;
        n_kind         = adcd_pkg::KIND_NONE;
        if (counted) begin
            n_last_hit_ms = i_event.now_ms;
            if (!r_armed) begin
                n_armed        = 1'b1;
                n_first_hit_ms = i_event.now_ms;
            end else if (in_window) begin
                n_armed = 1'b0;
                n_kind  = adcd_pkg::KIND_DOUBLE;
            end
        end
        // timeout only applies to an arm taken before this event
        if (r_armed && n_armed && !in_window) begin
            n_armed = 1'b0;
            n_kind  = adcd_pkg::KIND_SINGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_armed        <= 1'b0;
            r_last_hit_ms  <= '0;
            r_first_hit_ms <= '0;
        end else begin
            if (o_pop) begin
                r_valid        <= 1'b1;
                r_armed        <= n_armed;
                r_last_hit_ms  <= n_last_hit_ms;
                r_first_hit_ms <= n_first_hit_ms;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
        end
    end

endmodule

>>> hdl/accel_double_click_detector_top.sv
// Top level of the accelerometer double-click detector.
// Holds the configuration registers; instantiates adcd_front, adcd_fifo, adcd_back.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  sample   | in        | i_valid / o_stall      | i_accel_x/y/z, i_now_ms
//  click    | out       | o_valid / i_stall      | o_click_kind
//  config   | in        | i_cfg_we (no wait)     | i_cfg_index, i_cfg_wdata
//
// One sample per cycle sustained while o_stall is low; o_valid rises once an accepted sample
// has passed the square register, the queue entry and the output register.
// The back-end state update is a registered loop over the event queue head.
// Synchronous active-low reset clears state and loads default thresholds.
// Output stalls fill the DEPTH-entry queue before o_stall rises.
module accel_double_click_detector_top #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [adcd_pkg::ACCEL_W-1:0]   i_accel_x,
    input  logic signed [adcd_pkg::ACCEL_W-1:0]   i_accel_y,
    input  logic signed [adcd_pkg::ACCEL_W-1:0]   i_accel_z,
    input  logic        [adcd_pkg::TIME_W-1:0]    i_now_ms,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [adcd_pkg::KIND_W-1:0]    o_click_kind,
    input  logic                                  i_cfg_we,
    input  logic        [adcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [adcd_pkg::CFG_W-1:0]     i_cfg_wdata
);

    logic [adcd_pkg::CFG_W-1:0] r_hit_threshold;
    logic [adcd_pkg::CFG_W-1:0] r_debounce_ms;
    logic [adcd_pkg::CFG_W-1:0] r_double_window_ms;

    logic             push, pop, full, empty;
    adcd_pkg::t_event push_event, pop_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_threshold    <= adcd_pkg::RST_HIT_THRESHOLD;
            r_debounce_ms      <= adcd_pkg::RST_DEBOUNCE_MS;
            r_double_window_ms <= adcd_pkg::RST_DOUBLE_WINDOW_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                adcd_pkg::CFG_HIT_THRESHOLD:    r_hit_threshold    <= i_cfg_wdata;
                adcd_pkg::CFG_DEBOUNCE_MS:      r_debounce_ms      <= i_cfg_wdata;
                adcd_pkg::CFG_DOUBLE_WINDOW_MS: r_double_window_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    adcd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_now_ms        (i_now_ms),
        .i_hit_threshold (r_hit_threshold),
        .o_push          (push),
        .o_event         (push_event),
        .i_full          (full)
    );

    adcd_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_event (pop_event)
    );

    adcd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (empty),
        .i_event            (pop_event),
        .o_pop              (pop),
        .i_debounce_ms      (r_debounce_ms),
        .i_double_window_ms (r_double_window_ms),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_click_kind       (o_click_kind)
    );

endmodule
